FILE: rtl/wia128_pkg.sv
// Package: command and status codes, the queue item type and the default sizes.
`default_nettype none
package wia128_pkg;
  localparam int HALF_BITS = 64;
  localparam int DATA_BITS = 128;
  localparam int WORD_BITS_DEFAULT = 128;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_MUL = 4'd2;
  localparam logic [3:0] CMD_DIVMOD = 4'd3;
  localparam logic [3:0] CMD_AND = 4'd4;
  localparam logic [3:0] CMD_OR = 4'd5;
  localparam logic [3:0] CMD_XOR = 4'd6;
  localparam logic [3:0] CMD_NOT = 4'd7;
  localparam logic [3:0] CMD_SHL = 4'd8;
  localparam logic [3:0] CMD_SHR = 4'd9;
  localparam logic [3:0] CMD_CMP = 4'd10;
  localparam logic [3:0] CMD_FLS = 4'd11;
  localparam logic [3:0] CMD_FFS = 4'd12;
  localparam logic [3:0] CMD_POPCOUNT = 4'd13;
  localparam logic [3:0] CMD_TESTBIT = 4'd14;
  localparam logic [3:0] CMD_SETBIT = 4'd15;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SCAN0 = 2'd3;

  typedef struct packed {
    logic [3:0] command;
    logic [DATA_BITS-1:0] a;
    logic [DATA_BITS-1:0] b;
    logic [1:0] status;
  } item_t;
endpackage
`default_nettype wire

FILE: rtl/wia128_front.sv
// Front end: accepts input beats and classifies them, flagging error cases.
`default_nettype none
module wia128_front #(
  parameter int WORD_BITS = wia128_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  command,
  input  wire logic [63:0] a_low,
  input  wire logic [63:0] a_high,
  input  wire logic [63:0] b_low,
  input  wire logic [63:0] b_high,
  input  wire logic        q_full,
  output logic             push,
  output wia128_pkg::item_t item
);
  logic pos_ok;
  logic a_zero;
  logic b_zero;

  assign pos_ok = (b_high == 64'd0) && (b_low < 64'(WORD_BITS)) && (b_low < 64'd128);
  assign a_zero = (a_low == 64'd0) && (a_high == 64'd0);
  assign b_zero = (b_low == 64'd0) && (b_high == 64'd0);
  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  always_comb begin
    item.command = command;
    item.a = {a_high, a_low};
    item.b = {b_high, b_low};
    item.status = wia128_pkg::ST_OK;
    unique case (command) inside
      wia128_pkg::CMD_DIVMOD: begin
        if (b_zero) item.status = wia128_pkg::ST_DIV0;
      end
      wia128_pkg::CMD_SHL, wia128_pkg::CMD_SHR, wia128_pkg::CMD_TESTBIT,
      wia128_pkg::CMD_SETBIT: begin
        if (!pos_ok) item.status = wia128_pkg::ST_RANGE;
      end
      wia128_pkg::CMD_FLS, wia128_pkg::CMD_FFS: begin
        if (a_zero) item.status = wia128_pkg::ST_SCAN0;
      end
      default: begin
        item.status = wia128_pkg::ST_OK;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/wia128_queue.sv
// Queue between front and back ends.
`default_nettype none
module wia128_queue #(
  parameter int DEPTH = wia128_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire wia128_pkg::item_t din,
  output logic                   full,
  input  wire logic              pop,
  output logic                   q_valid,
  output wia128_pkg::item_t      dout
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wia128_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/wia128_back.sv
// Back end: combinational ops, iterative multiply and divide, output register.
`default_nettype none
module wia128_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire wia128_pkg::item_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [63:0]            result_low,
  output logic [63:0]            result_high,
  output logic [63:0]            remainder_low,
  output logic [63:0]            remainder_high,
  output logic [1:0]             flag,
  output logic [1:0]             status
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [127:0] a_r;
  logic [127:0] b_r;
  logic [127:0] acc;
  logic [127:0] quo;
  logic [127:0] rem;
  logic [63:0] prod;
  logic [2:0] sh_r;
  logic [7:0] cnt;
  logic is_div;

  logic out_free;
  logic take;
  logic load_simple;
  logic load_done;
  logic [127:0] s_res;
  logic [1:0] s_flag;
  logic [6:0] amt;
  logic [7:0] pc;
  logic [6:0] hi_idx;
  logic [6:0] lo_idx;
  logic [128:0] trial;
  logic [128:0] diff;

  assign out_free = !out_valid || !out_stall;
  assign take = q_valid && (state == S_IDLE) && out_free;
  assign pop = take;
  assign load_simple = take && !((head.status == wia128_pkg::ST_OK) &&
                       ((head.command == wia128_pkg::CMD_MUL) ||
                        (head.command == wia128_pkg::CMD_DIVMOD)));
  assign load_done = (state == S_DONE) && out_free;
  assign amt = head.b[6:0];
  assign trial = {rem, quo[127]};
  assign diff = trial - {1'b0, b_r};
  assign pc = 8'($countones(head.a));

  always_comb begin
    hi_idx = '0;
    lo_idx = '0;
    for (int i = 0; i < 128; i++) begin
      if (head.a[i]) hi_idx = 7'(i);
      if (head.a[127-i]) lo_idx = 7'(127-i);
    end
  end

  always_comb begin
    s_res = '0;
    s_flag = 2'b00;
    case (head.command)
      wia128_pkg::CMD_ADD: s_res = head.a + head.b;
      wia128_pkg::CMD_SUB: s_res = head.a - head.b;
      wia128_pkg::CMD_AND: s_res = head.a & head.b;
      wia128_pkg::CMD_OR: s_res = head.a | head.b;
      wia128_pkg::CMD_XOR: s_res = head.a ^ head.b;
      wia128_pkg::CMD_NOT: s_res = ~head.a;
      wia128_pkg::CMD_SHL: s_res = head.a << amt;
      wia128_pkg::CMD_SHR: s_res = head.a >> amt;
      wia128_pkg::CMD_CMP: begin
        if (head.a < head.b) s_flag = 2'b11;
        else if (head.a > head.b) s_flag = 2'b01;
      end
      wia128_pkg::CMD_FLS: s_res = 128'(hi_idx);
      wia128_pkg::CMD_FFS: s_res = 128'(lo_idx);
      wia128_pkg::CMD_POPCOUNT: s_res = 128'(pc);
      wia128_pkg::CMD_TESTBIT: s_flag = {1'b0, head.a[amt]};
      wia128_pkg::CMD_SETBIT: s_res = head.a | (128'd1 << amt);
      default: s_res = '0;
    endcase
    if (head.status != wia128_pkg::ST_OK) begin
      s_res = '0;
      s_flag = 2'b00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (load_simple || load_done) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take && !load_simple) begin
            cnt <= '0;
            state <= (head.command == wia128_pkg::CMD_MUL) ? S_MUL : S_DIV;
          end
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 8'd16) state <= S_DONE;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 8'd127) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && !load_simple) begin
      a_r <= head.a;
      b_r <= head.b;
      acc <= '0;
      quo <= head.a;
      rem <= '0;
      is_div <= (head.command == wia128_pkg::CMD_DIVMOD);
    end
    if (state == S_MUL) begin
      prod <= a_r[32*cnt[3:2] +: 32] * b_r[32*cnt[1:0] +: 32];
      sh_r <= 3'(cnt[3:2]) + 3'(cnt[1:0]);
      if (cnt != 8'd0) acc <= acc + (128'(prod) << {sh_r, 5'b0});
    end
    if (state == S_DIV) begin
      if (!diff[128]) begin
        rem <= diff[127:0];
        quo <= {quo[126:0], 1'b1};
      end else begin
        rem <= trial[127:0];
        quo <= {quo[126:0], 1'b0};
      end
    end
    if (load_simple) begin
      {result_high, result_low} <= s_res;
      {remainder_high, remainder_low} <= '0;
      flag <= s_flag;
      status <= head.status;
    end else if (load_done) begin
      {result_high, result_low} <= is_div ? quo : acc;
      {remainder_high, remainder_low} <= is_div ? rem : 128'd0;
      flag <= 2'b00;
      status <= wia128_pkg::ST_OK;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/wide_integer_alu_128_top.sv
// Top level: 128-bit unsigned ALU with decoupled front end, queue and back end.
// Add, subtract, logic, shifts, compare, scans, popcount and bit ops are
// computed combinationally in the back end, registered at the output, and
// sustain one beat per cycle while the output is not stalled. Multiply runs
// 32x32 partial products one per cycle; divmod is restoring division at one
// quotient bit per cycle. After a multiply or divide the back end returns to
// idle when its result is loaded and then takes the next item.
// Commands that hit an error case (zero divisor, bad position, scan of zero)
// are handled like the simple ops, with a zeroed result. The four-entry queue
// keeps accepting beats, until it is full, while the back end is busy with a multiply or divide.
`default_nettype none
module wide_integer_alu_128_top #(
  parameter int WORD_BITS = wia128_pkg::WORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = wia128_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  command,
  input  wire logic [63:0] a_low,
  input  wire logic [63:0] a_high,
  input  wire logic [63:0] b_low,
  input  wire logic [63:0] b_high,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result_low,
  output logic [63:0]      result_high,
  output logic [63:0]      remainder_low,
  output logic [63:0]      remainder_high,
  output logic [1:0]       flag,
  output logic [1:0]       status
);
  wia128_pkg::item_t f_item;
  wia128_pkg::item_t q_head;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  wia128_front #(.WORD_BITS(WORD_BITS)) u_front (
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .a_low(a_low), .a_high(a_high), .b_low(b_low), .b_high(b_high),
    .q_full(q_full), .push(push), .item(f_item)
  );

  wia128_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_item), .full(q_full),
    .pop(pop), .q_valid(q_valid), .dout(q_head)
  );

  wia128_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .head(q_head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_low(result_low), .result_high(result_high),
    .remainder_low(remainder_low), .remainder_high(remainder_high),
    .flag(flag), .status(status)
  );
endmodule
`default_nettype wire

FILE: rtl/wia128_checker.sv
// Port checker for the ALU top level, with its bind statement.
`default_nettype none
module wia128_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] result_low,
  input wire logic [63:0] result_high,
  input wire logic [63:0] remainder_low,
  input wire logic [63:0] remainder_high,
  input wire logic [1:0]  flag,
  input wire logic [1:0]  status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_low) && $stable(status))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != wia128_pkg::ST_OK) |->
      result_low == 64'd0 && result_high == 64'd0 && flag == 2'b00)
    else $error("error beat carries nonzero result");

  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flag != 2'b10)
    else $error("illegal flag code");

  a_rem_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (remainder_low != 64'd0 || remainder_high != 64'd0) |->
      status == wia128_pkg::ST_OK && flag == 2'b00)
    else $error("remainder on non-divide beat");
endmodule

bind wide_integer_alu_128_top wia128_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .result_low(result_low), .result_high(result_high),
  .remainder_low(remainder_low), .remainder_high(remainder_high),
  .flag(flag), .status(status)
);
`default_nettype wire

FILE: tb/tb_wide_integer_alu_128_top.sv
// Testbench: drives wide_integer_alu_128_top with directed and random beats and checks results.
`timescale 1ns / 100ps
`default_nettype none
module tb_wide_integer_alu_128_top;
  typedef struct {
    logic [63:0] res_lo;
    logic [63:0] res_hi;
    logic [63:0] rem_lo;
    logic [63:0] rem_hi;
    logic [1:0] flg;
    logic [1:0] st;
  } alu_result_t;

  typedef struct {
    logic [3:0] cmd;
    logic [127:0] a;
    logic [127:0] b;
    bit known;
    logic [127:0] res;
    logic [1:0] flg;
    logic [1:0] st;
  } vector_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [1:0] FLAG_LESS = 2'b11;
  localparam logic [1:0] FLAG_ONE = 2'b01;
  localparam logic [1:0] FLAG_ZERO = 2'b00;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] command = wia128_pkg::CMD_ADD;
  logic [63:0] a_low = '0, a_high = '0, b_low = '0, b_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] result_low, result_high, remainder_low, remainder_high;
  logic [1:0] flag, status;

  alu_result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 59;
  int beats_sent = 0;
  int beats_checked = 0;

  always #5 clk = ~clk;

  wide_integer_alu_128_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .a_low(a_low), .a_high(a_high), .b_low(b_low),
    .b_high(b_high), .out_valid(out_valid), .out_stall(out_stall),
    .result_low(result_low), .result_high(result_high),
    .remainder_low(remainder_low), .remainder_high(remainder_high),
    .flag(flag), .status(status)
  );

  function automatic alu_result_t compute_alu(logic [3:0] cmd, logic [127:0] a,
                                              logic [127:0] b);
    alu_result_t r;
    logic [127:0] v, q, rm;
    logic [128:0] wide;
    bit pos_ok;
    int i;
    r = '{default: '0};
    v = '0;
    q = '0;
    rm = '0;
    pos_ok = (b < 128);
    case (cmd)
      wia128_pkg::CMD_ADD: v = a + b;
      wia128_pkg::CMD_SUB: v = a - b;
      wia128_pkg::CMD_MUL: v = a * b;
      wia128_pkg::CMD_DIVMOD: begin
        if (b == 0) r.st = wia128_pkg::ST_DIV0;
        else begin
          for (i = 127; i >= 0; i--) begin
            wide = {rm, a[i]};
            if (wide >= {1'b0, b}) begin
              wide = wide - {1'b0, b};
              q[i] = 1'b1;
            end
            rm = wide[127:0];
          end
          v = q;
        end
      end
      wia128_pkg::CMD_AND: v = a & b;
      wia128_pkg::CMD_OR: v = a | b;
      wia128_pkg::CMD_XOR: v = a ^ b;
      wia128_pkg::CMD_NOT: v = ~a;
      wia128_pkg::CMD_SHL, wia128_pkg::CMD_SHR: begin
        if (!pos_ok) r.st = wia128_pkg::ST_RANGE;
        else v = (cmd == wia128_pkg::CMD_SHL) ? a << b[6:0] : a >> b[6:0];
      end
      wia128_pkg::CMD_CMP: r.flg = (a < b) ? FLAG_LESS : (a > b) ? FLAG_ONE : FLAG_ZERO;
      wia128_pkg::CMD_FLS, wia128_pkg::CMD_FFS: begin
        if (a == 0) r.st = wia128_pkg::ST_SCAN0;
        else if (cmd == wia128_pkg::CMD_FLS) begin
          for (i = 0; i < 128; i++) if (a[i]) v = 128'(i);
        end else begin
          for (i = 127; i >= 0; i--) if (a[i]) v = 128'(i);
        end
      end
      wia128_pkg::CMD_POPCOUNT: v = 128'($countones(a));
      wia128_pkg::CMD_TESTBIT: begin
        if (!pos_ok) r.st = wia128_pkg::ST_RANGE;
        else r.flg = {1'b0, a[b[6:0]]};
      end
      default: begin
        if (!pos_ok) r.st = wia128_pkg::ST_RANGE;
        else v = a | (128'd1 << b[6:0]);
      end
    endcase
    r.res_lo = v[63:0];
    r.res_hi = v[127:64];
    r.rem_lo = rm[63:0];
    r.rem_hi = rm[127:64];
    return r;
  endfunction

  function automatic logic [127:0] rand_wide();
    logic [127:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 128'd1 << $urandom_range(0, 127);
      3: v = {64'd0, $urandom(), $urandom()};
      4: v = 128'($urandom_range(0, 300));
      default: v = {$urandom(), $urandom(), $urandom(), $urandom()};
    endcase
    return v;
  endfunction

  task automatic send_beat(logic [3:0] cmd, logic [127:0] a, logic [127:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    a_low <= a[63:0];
    a_high <= a[127:64];
    b_low <= b[63:0];
    b_high <= b[127:64];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(compute_alu(cmd, a, b));
    beats_sent++;
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    alu_result_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("result_low", e.res_lo, result_low);
          check_field("result_high", e.res_hi, result_high);
          check_field("remainder_low", e.rem_lo, remainder_low);
          check_field("remainder_high", e.rem_hi, remainder_high);
          check_field("flag", 64'(e.flg), 64'(flag));
          check_field("status", 64'(e.st), 64'(status));
          beats_checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  vector_t vectors[] = '{
    '{wia128_pkg::CMD_ADD, '1, 128'd1, 1, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_SUB, '0, 128'd1, 1, '1, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_MUL, '1, '1, 1, 128'd1, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_DIVMOD, '1, '0, 1, '0, FLAG_ZERO, wia128_pkg::ST_DIV0},
    '{wia128_pkg::CMD_DIVMOD, '1, 128'd7, 0, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_DIVMOD, 128'd5, '1, 0, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_AND, '1, '0, 1, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_OR, '0, '1, 1, '1, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_XOR, '1, '1, 1, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_NOT, '0, '0, 1, '1, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_SHL, '1, 128'd127, 0, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_SHL, '1, 128'd128, 1, '0, FLAG_ZERO, wia128_pkg::ST_RANGE},
    '{wia128_pkg::CMD_SHR, '1, 128'd64, 0, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_SHR, '1, {64'd1, 64'd0}, 1, '0, FLAG_ZERO, wia128_pkg::ST_RANGE},
    '{wia128_pkg::CMD_CMP, '0, '1, 1, '0, FLAG_LESS, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_CMP, '1, '1, 1, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_CMP, '1, '0, 1, '0, FLAG_ONE, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_FLS, '1, '0, 1, 128'd127, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_FLS, '0, '0, 1, '0, FLAG_ZERO, wia128_pkg::ST_SCAN0},
    '{wia128_pkg::CMD_FFS, '1, '0, 1, '0, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_FFS, '0, '0, 1, '0, FLAG_ZERO, wia128_pkg::ST_SCAN0},
    '{wia128_pkg::CMD_POPCOUNT, '1, '0, 1, 128'd128, FLAG_ZERO, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_TESTBIT, '1, 128'd127, 1, '0, FLAG_ONE, wia128_pkg::ST_OK},
    '{wia128_pkg::CMD_TESTBIT, '1, '1, 1, '0, FLAG_ZERO, wia128_pkg::ST_RANGE},
    '{wia128_pkg::CMD_SETBIT, '0, 128'd127, 1, {1'b1, 127'd0}, FLAG_ZERO, wia128_pkg::ST_OK}
  };

  initial begin
    alu_result_t p;
    int phase, n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vectors[k]) begin
      if (vectors[k].known) begin
        p = compute_alu(vectors[k].cmd, vectors[k].a, vectors[k].b);
        if (p.res_lo !== vectors[k].res[63:0] || p.res_hi !== vectors[k].res[127:64] ||
            p.flg !== vectors[k].flg || p.st !== vectors[k].st) begin
          $error("table row %0d: predictor disagrees with expected value", k);
          errors++;
        end
      end
      send_beat(vectors[k].cmd, vectors[k].a, vectors[k].b);
    end
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 13 : 0;
      for (n = 0; n < RANDOM_ITEMS / 3; n++)
        send_beat(4'($urandom_range(0, 15)), rand_wide(), rand_wide());
    end
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d beats across all sixteen commands, %0d results checked.",
             beats_sent, beats_checked);
    $display("Covered error codes, operand extremes and three idle mixes.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
rtl/wia128_pkg.sv
rtl/wia128_front.sv
rtl/wia128_queue.sv
rtl/wia128_back.sv
rtl/wide_integer_alu_128_top.sv
rtl/wia128_checker.sv
tb/tb_wide_integer_alu_128_top.sv
